@@ rtl/core/blut_pkg.sv @@
`default_nettype none
package blut_pkg;

  localparam int OFF_MAX_W = 24;
  localparam int BKT_MAX_W = 12;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_COUNT  = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;
  localparam logic [1:0] MODE_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_NO_USER = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic                 id_ok;
    logic                 g_ok;
    logic [OFF_MAX_W-1:0] off;
    logic [6:0]           grp;
    logic [15:0]          cnt;
    logic [15:0]          lim;
    logic [BKT_MAX_W-1:0] nb;
    logic [3:0]           skip;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [6:0]  grp;
    logic [15:0] cnt;
    logic [15:0] lim;
  } rec_t;

  typedef enum logic [3:0] {
    S_CLRALL, S_IDLE, S_REC, S_UL, S_CLR, S_INS1, S_INS2, S_INS3,
    S_TOP, S_HEAD, S_WALK, S_GCNT, S_DONE
  } state_t;

  function automatic logic [BKT_MAX_W-1:0] bkt(input logic [15:0] lim,
                                               input logic [15:0] cnt,
                                               input logic [BKT_MAX_W-1:0] bmax);
    logic [15:0] d;
    d = (lim > cnt) ? lim - cnt : 16'd0;
    return (d > 16'(bmax)) ? bmax : d[BKT_MAX_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/bucketed_linked_user_table.sv @@
`default_nettype none
// channel | dir | tdata fields (low bit up)
// in_     | in  | mode, user_id, group, count, limit, random_skip
// out_    | out | status, found_user_id, found_count
// cfg_    | in  | user_id_base
// Set/count/remove, on dual-port memories with registered reads: a rejected id
// goes straight to the result; else the record is read and, when it moves, a
// remove unlinks and clears the user and an insert or relink links it at the
// new bucket head. Get: buckets are scanned down from the group's top, then up
// to 15 links are walked. The result is loaded into the output register as the item ends.
// After reset a clearing pass over max(USERS, GROUPS*BUCKETS) entries runs;
// in_tready stays low until it ends. A stalled result holds in the output
// register while up to two beats queue on the input side.
module bucketed_linked_user_table #(
  parameter int USERS   = 65536,
  parameter int GROUPS  = 128,
  parameter int BUCKETS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // mode, user_id, group, count, limit, random_skip
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // status, found_user_id, found_count
);
  import blut_pkg::*;

  logic [31:0] base_r;
  logic        busy, q_valid, q_pop;
  item_t       q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  blut_front #(.USERS(USERS), .GROUPS(GROUPS), .BUCKETS(BUCKETS)) u_front (
    .clk(clk), .rst_n(rst_n), .base(base_r), .busy(busy),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

  blut_back #(.USERS(USERS), .GROUPS(GROUPS), .BUCKETS(BUCKETS)) u_back (
    .clk(clk), .rst_n(rst_n), .base(base_r), .busy(busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
endmodule
`default_nettype wire

@@ rtl/core/blut_ram.sv @@
`default_nettype none
module blut_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] wa,
  input  wire logic [W-1:0]                         wd,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] ra,
  output logic      [W-1:0]                         rd
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule
`default_nettype wire

@@ rtl/core/blut_front.sv @@
`default_nettype none
module blut_front #(
  parameter int USERS   = 65536,
  parameter int GROUPS  = 128,
  parameter int BUCKETS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [31:0]   base,
  input  wire logic          busy,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [79:0]   in_tdata,
  output logic               q_valid,
  output blut_pkg::item_t    q_item,
  input  wire logic          q_pop
);
  import blut_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      it;
  logic [31:0] uid, off;
  logic        push;

  assign uid = in_tdata[33:2];
  assign off = uid - base;

  always_comb begin
    it       = '0;
    it.mode  = in_tdata[1:0];
    it.id_ok = (uid >= base) && (off < 32'(USERS)) && (off != 32'd0);
    it.g_ok  = 32'(in_tdata[40:34]) < 32'(GROUPS);
    it.off   = off[OFF_MAX_W-1:0];
    it.grp   = in_tdata[40:34];
    it.cnt   = in_tdata[56:41];
    it.lim   = in_tdata[72:57];
    it.nb    = bkt(in_tdata[72:57], in_tdata[56:41], BKT_MAX_W'(BUCKETS - 1));
    it.skip  = in_tdata[76:73];
  end

  assign in_tready = !busy && (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = cnt_r != 2'd0;
  assign q_item    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= it;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/blut_back.sv @@
`default_nettype none
module blut_back #(
  parameter int USERS   = 65536,
  parameter int GROUPS  = 128,
  parameter int BUCKETS = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [31:0]  base,
  output logic              busy,
  input  wire logic         q_valid,
  input  blut_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [55:0]       out_tdata
);
  import blut_pkg::*;

  localparam int UW   = $clog2(USERS);
  localparam int BW   = $clog2(BUCKETS);
  localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int HD   = GROUPS * BUCKETS;
  localparam int HW   = $clog2(HD);
  localparam int MAXD = (USERS > HD) ? USERS : HD;
  localparam int CW   = $clog2(MAXD);

  function automatic logic [HW-1:0] hidx(input logic [6:0] g, input logic [BW-1:0] b);
    return HW'(HW'(g) * HW'(BUCKETS)) + HW'(b);
  endfunction

  state_t st_r, st_nxt;
  item_t  it_r, it_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [HW-1:0] old_hi_r, old_hi_nxt, new_hi_r, new_hi_nxt;
  logic [BW-1:0] new_b_r, new_b_nxt, top_r, top_nxt;
  logic [6:0]    new_g_r, new_g_nxt;
  logic          ins_r, ins_nxt, rm_r, rm_nxt;
  logic [UW-1:0] h_r, h_nxt, cur_r, cur_nxt;
  logic [4:0]    n_r, n_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [31:0]   res_id_r, res_id_nxt;
  logic [15:0]   res_cnt_r, res_cnt_nxt;
  logic          ov_r, ov_nxt;
  logic [55:0]   od_r, od_nxt;

  logic          rec_we, prv_we, nxt_we, hd_we, tp_we;
  logic [UW-1:0] rec_wa, rec_ra, prv_wa, prv_ra, nxt_wa, nxt_ra;
  logic [39:0]   rec_wd, rec_rd;
  logic [UW-1:0] prv_wd, prv_rd, nxt_wd, nxt_rd, hd_wd, hd_rd;
  logic [HW-1:0] hd_wa, hd_ra;
  logic [GW-1:0] tp_wa, tp_ra;
  logic [BW-1:0] tp_wd, tp_rd;

  rec_t          rec;
  logic [UW-1:0] u;
  logic [BW-1:0] ob, nb, nb1, tdec;
  logic          rec_unl, rec_ins, rec_rm, walk_on, out_free;
  logic [UW-1:0] fin;

  assign rec      = rec_t'(rec_rd);
  assign u        = it_r.off[UW-1:0];
  assign ob       = BW'(bkt(rec.lim, rec.cnt, BKT_MAX_W'(BUCKETS - 1)));
  assign nb       = BW'(it_r.nb);
  assign nb1      = BW'(bkt(rec.lim, it_r.cnt, BKT_MAX_W'(BUCKETS - 1)));
  assign tdec     = top_r - BW'(1);
  assign walk_on  = (n_r < (5'(it_r.skip) + 5'd1)) && (nxt_rd != '0);
  assign fin      = (nxt_rd != '0) ? nxt_rd : cur_r;
  assign out_free = !ov_r || out_tready;
  assign busy     = st_r == S_CLRALL;
  assign q_pop    = (st_r == S_IDLE) && q_valid;

  always_comb begin
    rec_unl = 1'b0;
    rec_ins = 1'b0;
    rec_rm  = 1'b0;
    case (it_r.mode)
      MODE_SET: begin
        rec_ins = !rec.valid || (rec.grp != it_r.grp) || (ob != nb);
        rec_unl = rec.valid && ((rec.grp != it_r.grp) || (ob != nb));
      end
      MODE_COUNT: begin
        rec_unl = rec.valid && (rec.cnt != it_r.cnt);
        rec_ins = rec_unl;
      end
      MODE_REMOVE: begin
        rec_unl = rec.valid;
        rec_rm  = rec.valid;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLRALL: if (clr_r == CW'(MAXD - 1)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.mode == MODE_GET) begin
            st_nxt = q_item.g_ok ? S_TOP : S_DONE;
          end else if (!q_item.id_ok || (q_item.mode == MODE_SET && !q_item.g_ok)) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_REC;
          end
        end
      end
      S_REC:  st_nxt = rec_unl ? S_UL : (rec_ins ? S_INS1 : S_DONE);
      S_UL:   st_nxt = ins_r ? S_INS1 : (rm_r ? S_CLR : S_DONE);
      S_CLR:  st_nxt = S_DONE;
      S_INS1: st_nxt = S_INS2;
      S_INS2: st_nxt = S_INS3;
      S_INS3: st_nxt = S_DONE;
      S_TOP:  st_nxt = (tp_rd == '0) ? S_DONE : S_HEAD;
      S_HEAD: begin
        if (hd_rd != '0) st_nxt = S_WALK;
        else if (tdec == '0) st_nxt = S_DONE;
      end
      S_WALK: if (!walk_on) st_nxt = S_GCNT;
      S_GCNT: st_nxt = S_DONE;
      S_DONE: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    it_nxt      = it_r;
    clr_nxt     = clr_r;
    old_hi_nxt  = old_hi_r;
    new_hi_nxt  = new_hi_r;
    new_b_nxt   = new_b_r;
    new_g_nxt   = new_g_r;
    ins_nxt     = ins_r;
    rm_nxt      = rm_r;
    h_nxt       = h_r;
    cur_nxt     = cur_r;
    n_nxt       = n_r;
    top_nxt     = top_r;
    res_st_nxt  = res_st_r;
    res_id_nxt  = res_id_r;
    res_cnt_nxt = res_cnt_r;
    ov_nxt      = ov_r && !out_tready;
    od_nxt      = od_r;
    case (st_r)
      S_CLRALL: clr_nxt = clr_r + CW'(1);
      S_IDLE: begin
        it_nxt      = q_item;
        res_id_nxt  = '0;
        res_cnt_nxt = '0;
        res_st_nxt  = (q_item.mode == MODE_GET) ? ST_NO_USER :
                      (!q_item.id_ok || (q_item.mode == MODE_SET && !q_item.g_ok)) ?
                      ST_BAD_ID : ST_OK;
      end
      S_REC: begin
        ins_nxt    = rec_ins;
        rm_nxt     = rec_rm;
        old_hi_nxt = hidx(rec.grp, ob);
        new_g_nxt  = (it_r.mode == MODE_SET) ? it_r.grp : rec.grp;
        new_b_nxt  = (it_r.mode == MODE_SET) ? nb : nb1;
        new_hi_nxt = (it_r.mode == MODE_SET) ? hidx(it_r.grp, nb) : hidx(rec.grp, nb1);
      end
      S_INS2: h_nxt = hd_rd;
      S_TOP:  top_nxt = tp_rd;
      S_HEAD: begin
        if (hd_rd != '0) begin
          cur_nxt = hd_rd;
          n_nxt   = 5'd1;
        end else begin
          top_nxt = tdec;
        end
      end
      S_WALK: begin
        if (walk_on) begin
          cur_nxt = nxt_rd;
          n_nxt   = n_r + 5'd1;
        end else begin
          cur_nxt = fin;
        end
      end
      S_GCNT: begin
        res_st_nxt  = ST_OK;
        res_id_nxt  = 32'(cur_r) + base;
        res_cnt_nxt = rec.cnt;
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {6'd0, res_cnt_r, res_id_r, res_st_r};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rec_we = 1'b0; rec_wa = u;  rec_wd = '0; rec_ra = u;
    prv_we = 1'b0; prv_wa = u;  prv_wd = '0; prv_ra = u;
    nxt_we = 1'b0; nxt_wa = u;  nxt_wd = '0; nxt_ra = u;
    hd_we  = 1'b0; hd_wa  = new_hi_r; hd_wd = '0; hd_ra = new_hi_r;
    tp_we  = 1'b0; tp_wa  = GW'(it_r.grp); tp_wd = top_r; tp_ra = GW'(it_r.grp);
    case (st_r)
      S_CLRALL: begin
        rec_we = 32'(clr_r) < 32'(USERS);
        prv_we = rec_we;
        nxt_we = rec_we;
        hd_we  = 32'(clr_r) < 32'(HD);
        tp_we  = 32'(clr_r) < 32'(GROUPS);
        rec_wa = clr_r[UW-1:0];
        prv_wa = clr_r[UW-1:0];
        nxt_wa = clr_r[UW-1:0];
        hd_wa  = clr_r[HW-1:0];
        tp_wa  = clr_r[GW-1:0];
        tp_wd  = '0;
      end
      S_IDLE: begin
        rec_ra = q_item.off[UW-1:0];
        tp_ra  = GW'(q_item.grp);
      end
      S_REC: begin
        case (it_r.mode)
          MODE_SET: begin
            rec_we = 1'b1;
            rec_wd = {1'b1, it_r.grp, it_r.cnt, it_r.lim};
          end
          MODE_COUNT: begin
            rec_we = rec_unl;
            rec_wd = {1'b1, rec.grp, it_r.cnt, rec.lim};
          end
          MODE_REMOVE: rec_we = rec_rm;
          default: ;
        endcase
      end
      S_UL: begin
        if (prv_rd != '0) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd;
          nxt_wd = nxt_rd;
        end else begin
          hd_we = 1'b1;
          hd_wa = old_hi_r;
          hd_wd = nxt_rd;
        end
        prv_we = nxt_rd != '0;
        prv_wa = nxt_rd;
        prv_wd = prv_rd;
      end
      S_CLR: begin
        prv_we = 1'b1;
        nxt_we = 1'b1;
      end
      S_INS2: begin
        prv_we = 1'b1;
        nxt_we = 1'b1;
        nxt_wd = hd_rd;
        hd_we  = 1'b1;
        hd_wd  = u;
        tp_ra  = GW'(new_g_r);
      end
      S_INS3: begin
        tp_we  = new_b_r > tp_rd;
        tp_wa  = GW'(new_g_r);
        tp_wd  = new_b_r;
        prv_we = h_r != '0;
        prv_wa = h_r;
        prv_wd = u;
      end
      S_TOP:  hd_ra = hidx(it_r.grp, tp_rd);
      S_HEAD: begin
        hd_ra  = hidx(it_r.grp, tdec);
        nxt_ra = hd_rd;
        if (hd_rd == '0 && tdec == '0) begin
          tp_we = 1'b1;
          tp_wd = '0;
        end
      end
      S_WALK: begin
        nxt_ra = nxt_rd;
        rec_ra = fin;
      end
      S_GCNT: tp_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    it_r      <= it_nxt;
    old_hi_r  <= old_hi_nxt;
    new_hi_r  <= new_hi_nxt;
    new_b_r   <= new_b_nxt;
    new_g_r   <= new_g_nxt;
    ins_r     <= ins_nxt;
    rm_r      <= rm_nxt;
    h_r       <= h_nxt;
    cur_r     <= cur_nxt;
    n_r       <= n_nxt;
    top_r     <= top_nxt;
    res_st_r  <= res_st_nxt;
    res_id_r  <= res_id_nxt;
    res_cnt_r <= res_cnt_nxt;
    od_r      <= od_nxt;
    if (!rst_n) begin
      st_r  <= S_CLRALL;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  blut_ram #(.W(40), .D(USERS)) u_rec (
    .clk(clk), .we(rec_we), .wa(rec_wa), .wd(rec_wd), .ra(rec_ra), .rd(rec_rd));
  blut_ram #(.W(UW), .D(USERS)) u_prv (
    .clk(clk), .we(prv_we), .wa(prv_wa), .wd(prv_wd), .ra(prv_ra), .rd(prv_rd));
  blut_ram #(.W(UW), .D(USERS)) u_nxt (
    .clk(clk), .we(nxt_we), .wa(nxt_wa), .wd(nxt_wd), .ra(nxt_ra), .rd(nxt_rd));
  blut_ram #(.W(UW), .D(HD)) u_head (
    .clk(clk), .we(hd_we), .wa(hd_wa), .wd(hd_wd), .ra(hd_ra), .rd(hd_rd));
  blut_ram #(.W(BW), .D(GROUPS)) u_top (
    .clk(clk), .we(tp_we), .wa(tp_wa), .wd(tp_wd), .ra(tp_ra), .rd(tp_rd));
endmodule
`default_nettype wire
